// ===== hw/rtl/lpm_pkg.sv =====
// Shared types and constants for the longest-prefix-match routing table.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lpm_pkg;

   // Table size of the routing function.
   localparam int unsigned TableEntries = 16;
   // Slots that a write can reach (entry_index is 4 bits); slots beyond stay invalid.
   localparam int unsigned SlotLimit    = 16;
   localparam int unsigned RouteDepth   = (TableEntries < SlotLimit) ? TableEntries : SlotLimit;
   localparam int unsigned IdxW         = (RouteDepth > 1) ? $clog2(RouteDepth) : 1;

   localparam int unsigned EntryIdxW    = 4;
   localparam int unsigned AddrW        = 32;

   typedef logic [IdxW-1:0] lpm_idx_type;

   // func codes
   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_LOOKUP = 1'b1
   } lpm_func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HOLD
   } lpm_state_type;

   typedef struct packed {
      logic                 func;
      logic [EntryIdxW-1:0] entry_index;
      logic [AddrW-1:0]     entry_dest;
      logic [AddrW-1:0]     entry_mask;
      logic                 entry_valid;
      logic [AddrW-1:0]     lookup_addr;
   } lpm_req_type;

   typedef struct packed {
      logic                 hit;
      logic [EntryIdxW-1:0] match_index;
      logic [AddrW-1:0]     match_mask;
   } lpm_rsp_type;

   // One stored route: destination and mask
   typedef struct packed {
      logic [AddrW-1:0] dest;
      logic [AddrW-1:0] mask;
   } lpm_route_type;

   // Controls from the scan sequencer to the route memory
   typedef struct packed {
      logic          wr_en;
      lpm_idx_type   wr_addr;
      lpm_route_type wr_data;
      lpm_idx_type   rd_addr;
   } lpm_ram_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/longest_prefix_match_table.sv =====
// IPv4 longest-prefix-match routing table, top level.
// Instantiates lpm_scan and lpm_route_ram; depends on lpm_pkg.
//
// A write transfer (func 0) loads one slot with destination, mask and valid
// mark and gives no result. A lookup transfer (func 1) walks every slot once,
// one per cycle, through a route memory with a registered read, and returns
// the valid matching slot with the numerically largest mask (lowest slot on a
// tie; a mask of zero matches any address). A lookup stalls the input while
// it runs: the accept cycle issues the read of slot 0, then one compare per
// slot while the next read is in flight. The memory port is what paces the
// scan. The result goes into an output register, so a new transfer is taken
// while a result still waits; only if the previous result is still stalled
// when a scan ends does the block wait for it to drain. Valid bits live in
// flip-flops cleared by reset; destinations and masks are not cleared and
// are only used for valid slots. Writes to slots at or beyond the table size
// are dropped.

`default_nettype none

module longest_prefix_match_table (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  lpm_pkg::lpm_req_type req_data,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output lpm_pkg::lpm_rsp_type rsp_data
);
   import lpm_pkg::*;

   lpm_ram_ctl_type ram_ctl;
   lpm_route_type   ram_rd;

   // sequencer: handshake, valid bits, compare and result register
   lpm_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .ram_ctl   (ram_ctl),
      .ram_rd    (ram_rd)
   );

   // destination/mask storage
   lpm_route_ram u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_data (ram_rd)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/lpm_route_ram.sv =====
// Route memory: destination and mask per slot, one write and one read port.
// Read data registered. Depends on lpm_pkg.
`default_nettype none

module lpm_route_ram (
   input  wire                      clock,
   input  lpm_pkg::lpm_ram_ctl_type ctl,
   output lpm_pkg::lpm_route_type   rd_data
);
   import lpm_pkg::*;

   lpm_route_type mem [RouteDepth];
   lpm_route_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= mem[ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lpm_scan.sv =====
// Scan sequencer: accepts transfers, keeps valid bits, walks the route memory
// one slot a cycle and holds the result register. Depends on lpm_pkg.
`default_nettype none

module lpm_scan (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  lpm_pkg::lpm_req_type     req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output lpm_pkg::lpm_rsp_type     rsp_data,
   output lpm_pkg::lpm_ram_ctl_type ram_ctl,
   input  lpm_pkg::lpm_route_type   ram_rd
);
   import lpm_pkg::*;

   lpm_state_type       state_ff, state_in;
   logic [RouteDepth-1:0] route_valid_ff;
   logic                rd_valid_ff;
   lpm_idx_type         cmp_idx_ff;
   logic [AddrW-1:0]    addr_ff;
   logic                found_ff;
   lpm_idx_type         best_idx_ff;
   logic [AddrW-1:0]    best_mask_ff;
   logic                rsp_valid_ff;
   lpm_rsp_type         rsp_ff;

   logic          req_accept;
   logic          is_lookup;
   logic          slot_ok;
   logic          out_free;
   logic          last;
   logic          entry_hit;
   logic          take;
   logic          cand_found;
   lpm_idx_type   cand_idx;
   logic [AddrW-1:0] cand_mask;
   logic          load_rsp;
   lpm_rsp_type   rsp_in;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign is_lookup  = (req_data.func == FUNC_LOOKUP);
   assign slot_ok    = (32'(req_data.entry_index) < RouteDepth);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last       = (cmp_idx_ff == IdxW'(RouteDepth - 1));

   // compare stage on the entry read last cycle
   assign entry_hit  = rd_valid_ff && (((addr_ff ^ ram_rd.dest) & ram_rd.mask) == '0);
   assign take       = entry_hit && (!found_ff || (ram_rd.mask > best_mask_ff));
   assign cand_found = found_ff || entry_hit;
   assign cand_idx   = take ? cmp_idx_ff  : best_idx_ff;
   assign cand_mask  = take ? ram_rd.mask : best_mask_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_lookup) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last) state_in = out_free ? ST_IDLE : ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall       = 1'b1;
      load_rsp        = 1'b0;
      rsp_in          = rsp_ff;
      ram_ctl.wr_en   = 1'b0;
      ram_ctl.wr_addr = req_data.entry_index[IdxW-1:0];
      ram_ctl.wr_data = '{dest: req_data.entry_dest, mask: req_data.entry_mask};
      ram_ctl.rd_addr = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            ram_ctl.wr_en = req_accept && !is_lookup && slot_ok;
         end
         ST_SCAN: begin
            ram_ctl.rd_addr = cmp_idx_ff + IdxW'(1);
            load_rsp        = last && out_free;
            rsp_in          = '{hit:         cand_found,
                                match_index: EntryIdxW'(cand_idx),
                                match_mask:  cand_mask};
         end
         ST_HOLD: begin
            load_rsp = out_free;
            rsp_in   = '{hit:         found_ff,
                         match_index: EntryIdxW'(best_idx_ff),
                         match_mask:  best_mask_ff};
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         route_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (ram_ctl.wr_en) begin
            route_valid_ff[ram_ctl.wr_addr] <= req_data.entry_valid;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rd_valid_ff <= route_valid_ff[ram_ctl.rd_addr];
      if (req_accept && is_lookup) begin
         addr_ff      <= req_data.lookup_addr;
         cmp_idx_ff   <= '0;
         found_ff     <= 1'b0;
         best_idx_ff  <= '0;
         best_mask_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         cmp_idx_ff   <= cmp_idx_ff + IdxW'(1);
         found_ff     <= cand_found;
         best_idx_ff  <= cand_idx;
         best_mask_ff <= cand_mask;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== bench/lpm_match_tracker.sv =====
// Longest-prefix-match tracker for the routing table bench: shadow routes,
// best-match computation and the queue of pending lookup results.
// Depends on lpm_pkg for the transfer structs and the table size.
`timescale 1ns / 1ps

package lpm_bench_pkg;

   import lpm_pkg::*;

   class lpm_match_tracker;

      logic [AddrW-1:0] route_dest [TableEntries];
      logic [AddrW-1:0] route_mask [TableEntries];
      bit               route_valid[TableEntries];
      lpm_rsp_type      pending_matches[$];
      int unsigned      mismatches;

      function new();
         foreach (route_valid[i]) begin
            route_dest[i]  = '0;
            route_mask[i]  = '0;
            route_valid[i] = 1'b0;
         end
         mismatches = 0;
      endfunction

      // Walk every valid slot; keep the largest mask, lowest slot on a tie.
      function lpm_rsp_type longest_match(logic [AddrW-1:0] addr);
         lpm_rsp_type best;
         int          slot;
         best = '0;
         for (slot = 0; slot < TableEntries; slot++) begin
            if (route_valid[slot] &&
                ((addr & route_mask[slot]) == (route_dest[slot] & route_mask[slot])) &&
                (!best.hit || route_mask[slot] > best.match_mask)) begin
               best.hit         = 1'b1;
               best.match_index = EntryIdxW'(slot);
               best.match_mask  = route_mask[slot];
            end
         end
         return best;
      endfunction

      // Writes update the shadow table; lookups queue their expected match.
      function void accept_request(lpm_req_type item);
         if (item.func == FUNC_WRITE) begin
            if (item.entry_index < TableEntries) begin
               route_dest[item.entry_index]  = item.entry_dest;
               route_mask[item.entry_index]  = item.entry_mask;
               route_valid[item.entry_index] = item.entry_valid;
            end
         end else begin
            pending_matches.push_back(longest_match(item.lookup_addr));
         end
      endfunction

      function int unsigned outstanding();
         return pending_matches.size();
      endfunction

      task report(string what);
         $display("%0t: lookup mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_match(lpm_rsp_type got);
         lpm_rsp_type want;
         if (pending_matches.size() == 0) begin
            report($sformatf("unexpected result hit=%0b slot=%0d mask=%08h",
                             got.hit, got.match_index, got.match_mask));
            return;
         end
         want = pending_matches.pop_front();
         if (got.hit !== want.hit)
            report($sformatf("hit %0b, expected %0b", got.hit, want.hit));
         if (got.match_index !== want.match_index)
            report($sformatf("slot %0d, expected %0d", got.match_index, want.match_index));
         if (got.match_mask !== want.match_mask)
            report($sformatf("mask %08h, expected %08h", got.match_mask, want.match_mask));
      endtask

   endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for longest_prefix_match_table: directed and random route
// writes and lookups, random idling on both channels, per-field checking.
// Depends on lpm_pkg and lpm_bench_pkg (bench/lpm_match_tracker.sv).
`timescale 1ns / 1ps

module tb_top;

   import lpm_pkg::*;
   import lpm_bench_pkg::*;

   // Cycles with no transfer on either channel before the run is abandoned.
   // A correct run never gets near this: a sender gap, a scan and a receiver
   // stall together stay far below it.
   localparam int unsigned WatchdogLimit = 2000;
   localparam int unsigned ScanCycles    = TableEntries + 1;
   localparam int unsigned PhaseCount    = 7;
   localparam int unsigned PhaseItems    = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   lpm_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   lpm_rsp_type rsp_data;

   lpm_match_tracker routes;

   // Idling controls: an eager side never waits, giving back-to-back stretches.
   bit               req_eager = 1'b0;
   bit               rsp_eager = 1'b0;
   int unsigned      hold_left = 0;
   int unsigned      idle_cycles = 0;

   // Stimulus-side copy of what was written, used to aim lookups at routes.
   logic [AddrW-1:0] slot_dest[16];
   logic [AddrW-1:0] slot_mask[16];
   logic [AddrW-1:0] base_pool[4];

   longest_prefix_match_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Monitor: everything is sampled at the rising edge, before the block's
   // registers move. The result is checked before the input is noted; a
   // result never belongs to a lookup taken on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            routes.check_match(rsp_data);
            hold_left = rsp_eager ? 0 : $urandom_range(0, 19);
         end
         if (req_valid && !req_stall)
            routes.accept_request(req_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Receiver: each result is held off for its own drawn number of cycles.
   // Stall only rises once a result is on offer, so a stalled result can
   // overlap the end of the following scan.
   always @(negedge clock) begin
      if (rsp_valid && hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      while (idle_cycles < WatchdogLimit)
         @(posedge clock);
      $display("longest_prefix_match_table regression: fail");
      $finish;
   end

   // Write transfer; the lookup address is filled with noise.
   function automatic lpm_req_type mk_write(int unsigned slot, logic [AddrW-1:0] dest,
                                            logic [AddrW-1:0] mask, bit valid);
      lpm_req_type item;
      item.func        = FUNC_WRITE;
      item.entry_index = EntryIdxW'(slot);
      item.entry_dest  = dest;
      item.entry_mask  = mask;
      item.entry_valid = valid;
      item.lookup_addr = $urandom;
      slot_dest[slot]  = dest;
      slot_mask[slot]  = mask;
      return item;
   endfunction

   // Lookup transfer; the write fields are filled with noise.
   function automatic lpm_req_type mk_lookup(logic [AddrW-1:0] addr);
      lpm_req_type item;
      item.func        = FUNC_LOOKUP;
      item.entry_index = EntryIdxW'($urandom_range(0, 15));
      item.entry_dest  = $urandom;
      item.entry_mask  = $urandom;
      item.entry_valid = $urandom_range(0, 1);
      item.lookup_addr = addr;
      return item;
   endfunction

   // Route write: mostly contiguous prefixes over a few shared bases so that
   // routes nest; some copies of another slot (equal masks) and some
   // arbitrary masks.
   function automatic lpm_req_type random_route_write();
      int unsigned      pick;
      int unsigned      plen;
      int unsigned      twin;
      logic [AddrW-1:0] mask;
      logic [AddrW-1:0] dest;
      pick = $urandom_range(0, 99);
      plen = $urandom_range(1, 31);
      if (pick < 10)
         mask = '0;
      else if (pick < 20)
         mask = '1;
      else if (pick < 30)
         mask = $urandom;
      else
         mask = ~32'h0 << (32 - plen);
      dest = (base_pool[$urandom_range(0, 3)] & mask) | ($urandom & ~mask);
      if (pick >= 30 && pick < 40)
         dest = $urandom;
      if ($urandom_range(0, 9) == 0) begin
         twin = $urandom_range(0, 15);
         dest = slot_dest[twin];
         mask = slot_mask[twin];
      end
      return mk_write($urandom_range(0, 15), dest, mask, $urandom_range(0, 7) != 0);
   endfunction

   // Lookup mostly aimed inside a written route; the rest near a base,
   // fully random, or at the address extremes.
   function automatic lpm_req_type random_lookup();
      int unsigned pick;
      int unsigned slot;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, 15);
      if (pick < 55)
         return mk_lookup((slot_dest[slot] & slot_mask[slot]) | ($urandom & ~slot_mask[slot]));
      else if (pick < 70)
         return mk_lookup(base_pool[$urandom_range(0, 3)] ^ ($urandom >> $urandom_range(4, 31)));
      else if (pick < 90)
         return mk_lookup($urandom);
      else
         return mk_lookup(pick[0] ? 32'hFFFF_FFFF : 32'h0000_0000);
   endfunction

   // One transfer: optional idle gap, then hold valid and payload until the
   // block takes it. Valid stays high across back-to-back transfers.
   task automatic send_item(lpm_req_type item);
      int unsigned gap;
      gap = req_eager ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (!req_stall)
            break;
      end
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      routes = new();
      foreach (slot_dest[i]) begin
         slot_dest[i] = '0;
         slot_mask[i] = '0;
      end
      foreach (base_pool[i])
         base_pool[i] = $urandom;
      hold_left = $urandom_range(0, 19);
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, default route, nesting, host route, ties,
      // a non-contiguous mask, clearing writes and the address extremes.
      send_item(mk_lookup(32'h0000_0000));
      send_item(mk_lookup(32'hFFFF_FFFF));
      send_item(mk_write(0, 32'hDEAD_BEEF, 32'h0000_0000, 1'b1));
      send_item(mk_lookup(32'h0000_0000));
      send_item(mk_write(5, 32'h0A00_0000, 32'hFF00_0000, 1'b1));
      send_item(mk_lookup(32'h0A12_3456));
      send_item(mk_lookup(32'h0B00_0000));
      send_item(mk_write(3, 32'h0A12_0000, 32'hFFFF_0000, 1'b1));
      send_item(mk_lookup(32'h0A12_FFFF));
      send_item(mk_write(15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
      send_item(mk_lookup(32'hFFFF_FFFF));
      send_item(mk_lookup(32'hFFFF_FFFE));
      // equal masks: the lower slot wins
      send_item(mk_write(9, 32'h0A12_0000, 32'hFFFF_0000, 1'b1));
      send_item(mk_lookup(32'h0A12_0001));
      send_item(mk_write(1, 32'h0A12_0000, 32'hFFFF_0000, 1'b1));
      send_item(mk_lookup(32'h0A12_0001));
      // non-contiguous mask, numerically above the /16
      send_item(mk_write(7, 32'h0A12_0001, 32'hFFFF_0001, 1'b1));
      send_item(mk_lookup(32'h0A12_0001));
      send_item(mk_lookup(32'h0A12_0000));
      // clearing writes still load destination and mask
      send_item(mk_write(7, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
      send_item(mk_lookup(32'h0A12_0001));
      send_item(mk_write(0, 32'h1234_5678, 32'h0000_0000, 1'b0));
      send_item(mk_lookup(32'h0B00_0000));
      send_item(mk_write(4, 32'h0000_0000, 32'h8000_0000, 1'b1));
      send_item(mk_lookup(32'h7FFF_FFFF));

      // Random phases, each with fresh bases and its own idling mix.
      for (phase = 0; phase < PhaseCount; phase++) begin
         foreach (base_pool[i])
            base_pool[i] = $urandom;
         req_eager = ($urandom_range(0, 3) == 0);
         rsp_eager = ($urandom_range(0, 3) == 0);
         for (n = 0; n < PhaseItems; n++) begin
            if ($urandom_range(0, 99) < 60)
               send_item(random_lookup());
            else
               send_item(random_route_write());
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      rsp_eager = 1'b0;
      while (routes.outstanding() != 0)
         @(posedge clock);
      // let a trailing scan run out; a stray result would show up here
      repeat (2 * ScanCycles) @(posedge clock);

      if (routes.mismatches == 0 && routes.outstanding() == 0)
         $display("longest_prefix_match_table regression: pass");
      else
         $display("longest_prefix_match_table regression: fail");
      $finish;
   end

endmodule
